// ===== hdl/previous_greater_element_defines.svh =====
// ----------------------------------------------------------------------------
// previous_greater_element_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PREVIOUS_GREATER_ELEMENT_DEFINES_SVH
`define PREVIOUS_GREATER_ELEMENT_DEFINES_SVH

// checked only outside reset
`define PGE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define PGE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/pge_pkg.sv =====
// ----------------------------------------------------------------------------
// pge_pkg
// Shared types and constants of the previous greater element block.
// ----------------------------------------------------------------------------
`default_nettype none

package pge_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CAP_W    = 7;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // register index decode on paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic nonempty;
      logic top_le;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/pge_csr.sv =====
// ----------------------------------------------------------------------------
// pge_csr
// APB register slice holding the stack capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pge_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [pge_pkg::PDATA_W-1:0]  pwdata,
   output logic      [pge_pkg::PDATA_W-1:0]  prdata,
   output logic                              pready,
   output logic      [pge_pkg::CAP_W-1:0]    capacity
);

   logic [pge_pkg::CAP_W-1:0] capacity_ff;
   logic [pge_pkg::CAP_W-1:0] capacity_in;
   logic                      wr_hit;

   assign pready   = 1'b1;
   assign wr_hit   = psel && penable && pwrite && (paddr[2] == pge_pkg::REG_CAPACITY);
   assign capacity = capacity_ff;

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_hit) begin
         capacity_in = pwdata[pge_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= pge_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == pge_pkg::REG_CAPACITY) begin
         prdata = pge_pkg::PDATA_W'(capacity_ff);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pge_ctrl.sv =====
// ----------------------------------------------------------------------------
// pge_ctrl
// Sequencer: accepts a value, pops one entry a cycle, then finishes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire pge_pkg::status_type status,
   output pge_pkg::cmd_type         cmd
);

   pge_pkg::state_type state_ff;
   pge_pkg::state_type state_in;
   logic               pop_now;

   assign pop_now = status.nonempty && status.top_le;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pge_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pge_pkg::ST_SCAN;
            end
         end
         pge_pkg::ST_SCAN: begin
            if (!pop_now && status.out_free) begin
               state_in = pge_pkg::ST_IDLE;
            end
         end
         default: state_in = pge_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         pge_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pge_pkg::ST_SCAN: begin
            cmd.pop    = pop_now;
            cmd.finish = !pop_now && status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pge_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pge_dpath.sv =====
// ----------------------------------------------------------------------------
// pge_dpath
// Stack memory, count, registered top-of-stack read and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_dpath #(
   parameter int DEPTH      = pge_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pge_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pge_pkg::cmd_type              cmd,
   output pge_pkg::status_type                status,
   input  wire logic [pge_pkg::CAP_W-1:0]     capacity,
   input  wire logic [DATA_WIDTH-1:0]         req_value,
   input  wire logic                          req_restart,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic      [DATA_WIDTH-1:0]         rsp_greater_value,
   output logic                               rsp_overflow
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int KW = (CW > pge_pkg::CAP_W) ? CW : pge_pkg::CAP_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [CW-1:0]         count_dec;
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [DATA_WIDTH-1:0] rsp_greater_ff;
   logic                  rsp_overflow_ff;

   logic [KW-1:0]         cap_ext;
   logic [KW-1:0]         eff_cap;
   logic                  full;
   logic                  nonempty;
   logic                  we;
   logic [AW-1:0]         waddr;
   logic [AW-1:0]         raddr;

   assign cap_ext = KW'(capacity);

   always_comb begin
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = KW'(1);
      end else if (cap_ext > KW'(DEPTH)) begin
         eff_cap = KW'(DEPTH);
      end
   end

   assign full     = KW'(count_ff) >= eff_cap;
   assign nonempty = count_ff != '0;

   always_comb begin
      count_in = count_ff;
      we       = 1'b0;
      if (cmd.load && req_restart) begin
         count_in = '0;
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.finish && !full) begin
         count_in = count_ff + CW'(1);
         we       = 1'b1;
      end
   end

   // read port always tracks the entry under the next count
   assign count_dec = count_in - CW'(1);
   assign waddr     = count_ff[AW-1:0];
   assign raddr     = (count_in == '0) ? '0 : count_dec[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= value_ff;
      end
      if (we && (waddr == raddr)) begin
         rd_ff <= value_ff;
      end else begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.nonempty = nonempty;
   assign status.top_le   = $signed(rd_ff) <= $signed(value_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found_ff    <= nonempty;
         rsp_greater_ff  <= nonempty ? rd_ff : '1;
         rsp_overflow_ff <= full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_greater_value = rsp_greater_ff;
   assign rsp_overflow      = rsp_overflow_ff;

endmodule

`default_nettype wire

// ===== hdl/previous_greater_element.sv =====
// A value is accepted in idle; then the entries not greater than it are popped and,
// once the output is free, its result beat is issued. No new value is accepted until then;
// each value is popped at most once.
// The pop loop is one stack-memory read per cycle through the registered port.
// Reset (synchronous, active high) empties the stack, drops any pending result
// and sets capacity to 64; stack contents are not cleared.
// ----------------------------------------------------------------------------
// previous_greater_element
// Nearest earlier strictly greater value, found with a monotonic stack.
// ----------------------------------------------------------------------------
`default_nettype none

module previous_greater_element #(
   parameter int DEPTH      = pge_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pge_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [DATA_WIDTH-1:0]        req_value,
   input  wire logic                         req_restart,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_found,
   output logic      [DATA_WIDTH-1:0]        rsp_greater_value,
   output logic                              rsp_overflow,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pge_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [pge_pkg::PDATA_W-1:0]  pwdata,
   output logic      [pge_pkg::PDATA_W-1:0]  prdata,
   output logic                              pready
);

   pge_pkg::cmd_type          cmd;
   pge_pkg::status_type       status;
   logic [pge_pkg::CAP_W-1:0] capacity;

   pge_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   pge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pge_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .capacity          (capacity),
      .req_value         (req_value),
      .req_restart       (req_restart),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_greater_value (rsp_greater_value),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== hdl/pge_checker.sv =====
// ----------------------------------------------------------------------------
// pge_checker
// Port-level checks on the previous greater element block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "previous_greater_element_defines.svh"

module pge_checker #(
   parameter int DATA_WIDTH = pge_pkg::DATA_WIDTH_DEFAULT
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_found,
   input wire logic [DATA_WIDTH-1:0] rsp_greater_value
);

   `PGE_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result beat survived reset")

   `PGE_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready while busy")

   `PGE_ASSERT(a_none_is_all_ones, (rsp_valid && !rsp_found) |-> (rsp_greater_value == '1), "missing value not all ones")

   `PGE_ASSERT(a_rsp_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) && $stable(rsp_greater_value)), "stalled result beat changed")

endmodule

bind previous_greater_element pge_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pge_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_previous_greater_element.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_previous_greater_element
// Self-checking bench for the nearest-greater-to-the-left stack block. A
// scoreboard keeps its own copy of the stack and the capacity setting and
// predicts every result beat. Directed extremes come first, then a stack fill
// to overflow. Several capacity settings follow, each with a phase of random
// runs that are falling, rising, narrow, wide or at the extremes. Sender gaps
// and receiver stalls are random, each switched off in some capacity phases.
// ----------------------------------------------------------------------------

module tb_previous_greater_element;

   localparam int DEPTH          = pge_pkg::DEPTH_DEFAULT;
   localparam int DW             = pge_pkg::DATA_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 81;
   localparam int DRAIN_CYCLES   = DEPTH + 40;

   localparam logic [pge_pkg::PADDR_W-1:0] CAPACITY_ADDR = {pge_pkg::REG_CAPACITY, 2'b00};
   localparam logic [pge_pkg::PADDR_W-1:0] UNMAPPED_ADDR = {~pge_pkg::REG_CAPACITY, 2'b00};

   localparam logic [DW-1:0] MAX_VALUE = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MIN_VALUE = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] NOT_FOUND = '1;

   typedef enum int {PAT_WIDE, PAT_NARROW, PAT_FALL, PAT_RISE, PAT_EDGE} pattern_type;

   class greater_scoreboard;
      typedef struct packed {
         logic          found;
         logic [DW-1:0] greater;
         logic          overflow;
      } answer_type;

      logic [DW-1:0]               left_stack [DEPTH];
      int unsigned                 stack_used;
      logic [pge_pkg::CAP_W-1:0]   capacity;
      answer_type                  expected_answers [$];
      int                          errors;

      function new();
         stack_used = 0;
         capacity   = pge_pkg::CAP_RESET;
         errors     = 0;
      endfunction

      function void set_capacity(logic [pge_pkg::CAP_W-1:0] c);
         capacity = c;
      endfunction

      function int outstanding();
         return expected_answers.size();
      endfunction

      function void note_value(logic [DW-1:0] v, logic restart);
         answer_type  a;
         int unsigned limit;
         limit = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
         if (restart)
            stack_used = 0;
         while (stack_used > 0 && $signed(left_stack[stack_used-1]) <= $signed(v))
            stack_used--;
         a.found    = (stack_used > 0);
         a.greater  = a.found ? left_stack[stack_used-1] : NOT_FOUND;
         a.overflow = (stack_used >= limit);
         if (!a.overflow) begin
            left_stack[stack_used] = v;
            stack_used++;
         end
         expected_answers.push_back(a);
      endfunction

      function void check_result(logic found, logic [DW-1:0] greater, logic overflow);
         answer_type a;
         if (expected_answers.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
         end
         a = expected_answers.pop_front();
         if (found !== a.found) begin
            $error("found: expected %0d, actual %0d", a.found, found);
            errors++;
         end
         if (greater !== a.greater) begin
            $error("greater_value: expected %0d, actual %0d",
                   $signed(a.greater), $signed(greater));
            errors++;
         end
         if (overflow !== a.overflow) begin
            $error("overflow: expected %0d, actual %0d", a.overflow, overflow);
            errors++;
         end
      endfunction
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   logic [DW-1:0]               req_value   = '0;
   logic                        req_restart = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   logic                        rsp_found;
   logic [DW-1:0]               rsp_greater_value;
   logic                        rsp_overflow;
   logic                        psel        = 1'b0;
   logic                        penable     = 1'b0;
   logic                        pwrite      = 1'b0;
   logic [pge_pkg::PADDR_W-1:0] paddr       = '0;
   logic [pge_pkg::PDATA_W-1:0] pwdata      = '0;
   logic [pge_pkg::PDATA_W-1:0] prdata;
   logic                        pready;

   greater_scoreboard board = new();

   int          quiet_cycles    = 0;
   int          burst_left      = 0;
   int          stall_left      = 0;
   bit          sender_gaps     = 1'b1;
   bit          receiver_stalls = 1'b1;
   pattern_type value_pattern   = PAT_WIDE;
   int          pattern_left    = 0;
   longint      trend           = 0;

   previous_greater_element u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_greater_value (rsp_greater_value),
      .rsp_overflow      (rsp_overflow),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_found, rsp_greater_value, rsp_overflow);
         if (req_valid && req_ready)
            board.note_value(req_value, req_restart);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [DW-1:0] v, input logic restart);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = 0;
         if (sender_gaps && $urandom_range(0, 3) != 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid   = 1'b1;
      req_value   = v;
      req_restart = restart;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [pge_pkg::PADDR_W-1:0] addr,
                            input logic [pge_pkg::CAP_W-1:0] c);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = {8'($urandom_range(0, 255)),
                 {(pge_pkg::PDATA_W-pge_pkg::CAP_W-8){1'b0}}, c};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CAPACITY_ADDR)
         board.set_capacity(c);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic [DW-1:0] next_value();
      logic [DW-1:0] v;
      case (value_pattern)
         PAT_NARROW: v = DW'(int'($urandom_range(0, 16)) - 8);
         PAT_FALL: begin
            trend -= ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(1, 5000));
            if (trend < -longint'(2)**(DW-1))
               trend = longint'(2)**(DW-1) - 1 - longint'($urandom_range(0, 3));
            v = trend[DW-1:0];
         end
         PAT_RISE: begin
            trend += ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(1, 5000));
            if (trend > longint'(2)**(DW-1) - 1)
               trend = -longint'(2)**(DW-1) + longint'($urandom_range(0, 3));
            v = trend[DW-1:0];
         end
         PAT_EDGE: begin
            case ($urandom_range(0, 5))
               0:       v = MAX_VALUE;
               1:       v = MIN_VALUE;
               2:       v = '0;
               3:       v = NOT_FOUND;
               4:       v = DW'(1);
               default: v = MIN_VALUE + 1;
            endcase
         end
         default:    v = $urandom;
      endcase
      return v;
   endfunction

   task automatic random_phase(input int count);
      int  pick;
      logic restart;
      for (int i = 0; i < count; i++) begin
         restart = ($urandom_range(0, 59) == 0);
         if (pattern_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      value_pattern = PAT_FALL;
            else if (pick < 55) value_pattern = PAT_WIDE;
            else if (pick < 75) value_pattern = PAT_NARROW;
            else if (pick < 90) value_pattern = PAT_RISE;
            else                value_pattern = PAT_EDGE;
            pattern_left = (value_pattern == PAT_FALL) ? $urandom_range(1, 80)
                                                       : $urandom_range(1, 20);
            trend = longint'($signed(DW'($urandom)));
            if ($urandom_range(0, 5) == 0)
               restart = 1'b1;
         end
         pattern_left--;
         if ($urandom_range(0, 149) == 0)
            drain_results();
         send_item(next_value(), restart);
      end
   endtask

   logic [DW-1:0]             directed_value   [20];
   logic                      directed_restart [20];
   logic [pge_pkg::CAP_W-1:0] phase_capacity   [10];

   initial begin
      directed_value = '{32'd5, MAX_VALUE, MIN_VALUE, NOT_FOUND, NOT_FOUND, 32'd0,
                         MAX_VALUE, 32'd100, 32'd50, 32'd50, 32'd75, MIN_VALUE,
                         MIN_VALUE, MIN_VALUE + 1, -32'sd2, -32'sd3, 32'd1,
                         32'h5555_5555, 32'hAAAA_AAAA, MAX_VALUE};
      directed_restart = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                           1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      phase_capacity = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd64,
                         pge_pkg::CAP_W'($urandom_range(1, 63)),
                         pge_pkg::CAP_W'($urandom_range(1, 127)),
                         pge_pkg::CAP_W'($urandom_range(1, 127))};

      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 20; i++)
         send_item(directed_value[i], directed_restart[i]);

      // fill to capacity and past it; the stack stays deep for the lowered setting
      for (int i = 0; i < DEPTH + 2; i++)
         send_item(DW'(1000 - i), i == 0);

      for (int p = 0; p < 10; p++) begin
         drain_results();
         if (p == 3)
            write_reg(UNMAPPED_ADDR, 7'd5);
         write_reg(CAPACITY_ADDR, phase_capacity[p]);
         sender_gaps     = (p % 3 != 0);
         receiver_stalls = (p % 4 != 1);
         pattern_left    = 0;
         random_phase(PHASE_ITEMS);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
